@@ hw/rtl/pct_pkg.sv @@
package pct_pkg;

	localparam int TABLE_ENTRIES_DEF = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [15:0] COOLDOWN_RESET = 16'd120;
	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		OUT_KNOWN_OK = 3'd0,
		OUT_NEW_FREE = 3'd1,
		OUT_EVICTED  = 3'd2,
		OUT_INVALID  = 3'd3,
		OUT_STALE    = 3'd4,
		OUT_COOLING  = 3'd5
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_REDUCE,
		ST_EVICT
	} back_state_t;

	// A classified request as it waits in the queue.
	typedef struct packed {
		logic        invalid;
		logic [15:0] source_id;
		logic [31:0] sequence_number;
		logic [31:0] now_time;
		logic [31:0] next_time;
	} req_t;

endpackage

@@ hw/rtl/per_source_cooldown_table.sv @@
// A result is registered on m_tvalid once its request has left the queue and
// passed the table lookup. The back takes one request at a time (queue pop, then
// the lookup); a new source that must evict also passes through the
// registered minimum tree over the entries' next times before it is written.
// Reset (arst_n low, asynchronous): the table is cleared to all free entries,
// the queue and output are emptied, and cooldown_interval returns to 120.
module per_source_cooldown_table #(
	parameter int TABLE_ENTRIES = pct_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // source_id[15:0], sequence_number[47:16], now_time[79:48]
	// Result channel.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // accepted[0], outcome[3:1], zero[7:4]
	// Configuration channel for cooldown_interval.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	// The user must write the cooldown register only while the block is idle (the block
	// does not enforce this), so the front may use it directly when it classifies a request.
	logic [15:0]   cooldown_q;
	pct_pkg::req_t front_req;
	pct_pkg::req_t q_data;
	logic          q_full;
	logic          q_not_empty;
	logic          q_pop;
	logic          push;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign push      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_q <= pct_pkg::COOLDOWN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cooldown_q <= cfg_data;
		end
	end

	// The front unpacks each transfer, flags invalid requests and works out
	// the saturated next allowed time.
	pct_front u_front (
		.s_tdata    (s_tdata),
		.cooldown_q (cooldown_q),
		.req        (front_req)
	);

	// A short queue decouples request intake from the table work.
	pct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_req),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_data)
	);

	// The back owns the table: lookup, update, eviction and the result register.
	pct_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

@@ hw/rtl/pct_front.sv @@
module pct_front (
	input  logic [79:0]        s_tdata,
	input  logic [15:0]        cooldown_q,
	output pct_pkg::req_t      req
);

	logic [32:0] sum;

	always_comb begin
		req.source_id       = s_tdata[15:0];
		req.sequence_number = s_tdata[47:16];
		req.now_time        = s_tdata[79:48];
		req.invalid         = (req.source_id == 16'd0) || (req.sequence_number == 32'd0);
		sum = {1'b0, req.now_time} + {17'd0, cooldown_q};
		// Saturate the next allowed time instead of wrapping.
		req.next_time = sum[32] ? pct_pkg::TIME_MAX : sum[31:0];
	end

endmodule

@@ hw/rtl/pct_queue.sv @@
module pct_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pct_pkg::req_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output pct_pkg::req_t pop_data
);

	localparam int DEPTH = pct_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pct_pkg::req_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/pct_back.sv @@
module pct_back #(
	parameter int TABLE_ENTRIES = pct_pkg::TABLE_ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_not_empty,
	input  pct_pkg::req_t q_data,
	output logic          q_pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata
);

	localparam int N     = TABLE_ENTRIES;
	localparam int IDX_W = (N > 1) ? $clog2(N) : 1;
	localparam int LVLS  = $clog2(N);
	localparam int LVL_W = (LVLS > 1) ? $clog2(LVLS) : 1;

	logic [15:0] ent_src_q  [N];
	logic [31:0] ent_seq_q  [N];
	logic [31:0] ent_next_q [N];

	logic [IDX_W-1:0] cand_idx_q  [N];
	logic [31:0]      cand_time_q [N];
	logic [IDX_W-1:0] red_idx     [N];
	logic [31:0]      red_time    [N];

	pct_pkg::req_t          item_q;
	pct_pkg::back_state_t   state_q, state_d;
	logic [LVL_W-1:0]       lvl_q;

	logic                   out_valid_q;
	logic                   out_acc_q;
	pct_pkg::outcome_t      out_code_q;

	logic                   hit, free_hit;
	logic [IDX_W-1:0]       hit_idx, free_idx;
	logic                   stale, cooling;

	logic                   wr_en;
	logic [IDX_W-1:0]       wr_idx;
	logic                   emit;
	logic                   emit_acc;
	pct_pkg::outcome_t      emit_code;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_code_q, out_acc_q};

	// First matching entry and first free entry.
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		free_hit = 1'b0;
		free_idx = '0;
		for (int i = 0; i < N; i++) begin
			if (!hit && ent_src_q[i] == item_q.source_id) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!free_hit && ent_src_q[i] == 16'd0) begin
				free_hit = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
		stale   = (item_q.sequence_number <= ent_seq_q[hit_idx]);
		cooling = (item_q.now_time < ent_next_q[hit_idx]);
	end

	// One level of the minimum tree; the left candidate wins ties.
	for (genvar g = 0; g < N; g++) begin : g_red
		if (2 * g + 1 < N) begin : g_pair
			always_comb begin
				if (cand_time_q[2*g+1] < cand_time_q[2*g]) begin
					red_idx[g]  = cand_idx_q[2*g+1];
					red_time[g] = cand_time_q[2*g+1];
				end else begin
					red_idx[g]  = cand_idx_q[2*g];
					red_time[g] = cand_time_q[2*g];
				end
			end
		end else if (2 * g < N) begin : g_single
			assign red_idx[g]  = cand_idx_q[2*g];
			assign red_time[g] = cand_time_q[2*g];
		end else begin : g_none
			assign red_idx[g]  = cand_idx_q[g];
			assign red_time[g] = cand_time_q[g];
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		wr_en     = 1'b0;
		wr_idx    = hit_idx;
		emit      = 1'b0;
		emit_acc  = 1'b0;
		emit_code = pct_pkg::OUT_INVALID;
		unique case (state_q)
			pct_pkg::ST_IDLE: begin
				if (q_not_empty && (!out_valid_q || m_tready)) begin
					q_pop   = 1'b1;
					state_d = pct_pkg::ST_LOOK;
				end
			end
			pct_pkg::ST_LOOK: begin
				if (item_q.invalid) begin
					emit      = 1'b1;
					emit_code = pct_pkg::OUT_INVALID;
					state_d   = pct_pkg::ST_IDLE;
				end else if (hit) begin
					emit    = 1'b1;
					state_d = pct_pkg::ST_IDLE;
					if (stale) begin
						emit_code = pct_pkg::OUT_STALE;
					end else if (cooling) begin
						emit_code = pct_pkg::OUT_COOLING;
					end else begin
						wr_en     = 1'b1;
						emit_acc  = 1'b1;
						emit_code = pct_pkg::OUT_KNOWN_OK;
					end
				end else if (free_hit) begin
					wr_en     = 1'b1;
					wr_idx    = free_idx;
					emit      = 1'b1;
					emit_acc  = 1'b1;
					emit_code = pct_pkg::OUT_NEW_FREE;
					state_d   = pct_pkg::ST_IDLE;
				end else begin
					state_d = (LVLS == 0) ? pct_pkg::ST_EVICT : pct_pkg::ST_REDUCE;
				end
			end
			pct_pkg::ST_REDUCE: begin
				if (lvl_q == LVL_W'(LVLS - 1)) begin
					state_d = pct_pkg::ST_EVICT;
				end
			end
			pct_pkg::ST_EVICT: begin
				wr_en     = 1'b1;
				wr_idx    = cand_idx_q[0];
				emit      = 1'b1;
				emit_acc  = 1'b1;
				emit_code = pct_pkg::OUT_EVICTED;
				state_d   = pct_pkg::ST_IDLE;
			end
			default: begin
				state_d = pct_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pct_pkg::ST_IDLE;
			lvl_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < N; i++) begin
				ent_src_q[i]  <= '0;
				ent_seq_q[i]  <= '0;
				ent_next_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == pct_pkg::ST_REDUCE) begin
				lvl_q <= lvl_q + 1'b1;
			end else begin
				lvl_q <= '0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				ent_src_q[wr_idx]  <= item_q.source_id;
				ent_seq_q[wr_idx]  <= item_q.sequence_number;
				ent_next_q[wr_idx] <= item_q.next_time;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_data;
		end
		if (emit) begin
			out_acc_q  <= emit_acc;
			out_code_q <= emit_code;
		end
		if (state_q == pct_pkg::ST_LOOK) begin
			for (int i = 0; i < N; i++) begin
				cand_idx_q[i]  <= IDX_W'(i);
				cand_time_q[i] <= ent_next_q[i];
			end
		end else if (state_q == pct_pkg::ST_REDUCE) begin
			for (int i = 0; i < N; i++) begin
				cand_idx_q[i]  <= red_idx[i];
				cand_time_q[i] <= red_time[i];
			end
		end
	end

endmodule

@@ hw/rtl/pct_checker.sv @@
module pct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:1] <= pct_pkg::OUT_COOLING))
		else $error("illegal outcome code");

	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] <= pct_pkg::OUT_EVICTED)))
		else $error("accepted flag disagrees with outcome");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:4] == 4'd0)
		else $error("result padding not zero");

endmodule

bind per_source_cooldown_table pct_checker u_pct_checker (.*);

@@ dv/testbench.sv @@
module testbench;

	// One expected answer of the limiter: the grant bit and the reason code.
	typedef struct packed {
		logic              accepted;
		pct_pkg::outcome_t outcome;
	} verdict_t;

	// Generous ceiling on the run length, in clock cycles.
	localparam int CYCLE_LIMIT = 400000;
	// Length of the long receiver hold-off that backs the block up.
	localparam int HOLD_CYCLES = 300;
	// Items per random phase; six phases give roughly 900 requests.
	localparam int PHASE_ITEMS = 150;
	localparam int POOL_MAX = 16;

	// The scoreboard keeps its own copy of the source table and the cooldown,
	// predicts the verdict of every request at the moment of its transfer and
	// checks each result transfer against the oldest pending verdict.
	class cooldown_scoreboard;
		logic [15:0] cooldown;
		logic [15:0] src_tab[pct_pkg::TABLE_ENTRIES_DEF];
		logic [31:0] seq_tab[pct_pkg::TABLE_ENTRIES_DEF];
		logic [31:0] next_tab[pct_pkg::TABLE_ENTRIES_DEF];
		verdict_t    verdict_q[$];
		int          errors;

		function new();
			cooldown = pct_pkg::COOLDOWN_RESET;
			errors = 0;
			for (int i = 0; i < pct_pkg::TABLE_ENTRIES_DEF; i++) begin
				src_tab[i] = '0;
				seq_tab[i] = '0;
				next_tab[i] = '0;
			end
		endfunction

		function void set_cooldown(logic [15:0] value);
			cooldown = value;
		endfunction

		// Time of the next allowed request, held at the top of the range.
		function logic [31:0] earliest_next(logic [31:0] now);
			logic [32:0] sum;
			sum = {1'b0, now} + {17'd0, cooldown};
			return sum[32] ? pct_pkg::TIME_MAX : sum[31:0];
		endfunction

		// Decide one request and update the table as the block should.
		function verdict_t judge(logic [15:0] src, logic [31:0] seq, logic [31:0] now);
			verdict_t v;
			int free_slot;
			int oldest;
			int slot;
			free_slot = -1;
			oldest = 0;
			if (src == '0 || seq == '0) begin
				v = '{accepted: 1'b0, outcome: pct_pkg::OUT_INVALID};
				return v;
			end
			for (int i = 0; i < pct_pkg::TABLE_ENTRIES_DEF; i++) begin
				if (src_tab[i] == src) begin
					// The replay check wins over the cooldown check.
					if (seq <= seq_tab[i]) begin
						v = '{accepted: 1'b0, outcome: pct_pkg::OUT_STALE};
						return v;
					end
					if (now < next_tab[i]) begin
						v = '{accepted: 1'b0, outcome: pct_pkg::OUT_COOLING};
						return v;
					end
					seq_tab[i] = seq;
					next_tab[i] = earliest_next(now);
					v = '{accepted: 1'b1, outcome: pct_pkg::OUT_KNOWN_OK};
					return v;
				end
				if (src_tab[i] == '0 && free_slot < 0)
					free_slot = i;
				// Strict compare, so a tie keeps the lowest index.
				if (next_tab[i] < next_tab[oldest])
					oldest = i;
			end
			slot = (free_slot >= 0) ? free_slot : oldest;
			src_tab[slot] = src;
			seq_tab[slot] = seq;
			next_tab[slot] = earliest_next(now);
			if (free_slot >= 0)
				v = '{accepted: 1'b1, outcome: pct_pkg::OUT_NEW_FREE};
			else
				v = '{accepted: 1'b1, outcome: pct_pkg::OUT_EVICTED};
			return v;
		endfunction

		function void note_request(logic [15:0] src, logic [31:0] seq, logic [31:0] now);
			verdict_q.push_back(judge(src, seq, now));
		endfunction

		function void check_result(logic [7:0] beat);
			verdict_t want;
			if (verdict_q.size() == 0) begin
				$error("result transfer with no request pending: tdata %02h", beat);
				errors++;
				return;
			end
			want = verdict_q.pop_front();
			if (beat[0] !== want.accepted) begin
				$error("accepted: expected %0d, actual %0d", want.accepted, beat[0]);
				errors++;
			end
			if (beat[3:1] !== want.outcome) begin
				$error("outcome: expected %0d (%s), actual %0d",
					want.outcome, want.outcome.name(), beat[3:1]);
				errors++;
			end
			if (beat[7:4] !== 4'd0) begin
				$error("padding: expected 0, actual %0h", beat[7:4]);
				errors++;
			end
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;  // source_id[15:0], sequence_number[47:16], now_time[79:48]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;  // accepted[0], outcome[3:1], zero[7:4]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	cooldown_scoreboard sb = new();

	// Set by the stimulus, cleared by the receiver once its hold-off is over.
	bit hold_off = 1'b0;
	int cycle_count = 0;

	// Stimulus-side view of the traffic: a pool of active sources with the
	// last sequence each one used, and a running millisecond clock.
	logic [15:0] pool_src[POOL_MAX];
	logic [31:0] pool_seq[POOL_MAX];
	int          pool_n;
	logic [31:0] clock_ms;
	logic [15:0] cur_cooldown;

	per_source_cooldown_table uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("per_source_cooldown_table: mismatch");
				$finish;
			end
		end
	end

	// Every result transfer is checked against the oldest prediction. The
	// outputs are read at the edge, before the block's own updates land.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_result(m_tdata);
		end
	end

	// Receiver: cycles through several stall patterns of its own, and on
	// request holds tready low for a long stretch so that the block backs up.
	initial begin
		int stall_cycle;
		int mode;
		stall_cycle = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end
			stall_cycle++;
			mode = (stall_cycle / 97) % 4;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ((stall_cycle % 5) != 0);
			endcase
		end
	end

	// Offer one request and hold it until the block takes it. The prediction
	// is made at the transfer edge, so it follows the block's own order.
	task automatic push_request(logic [15:0] src, logic [31:0] seq, logic [31:0] now);
		s_tdata <= {now, seq, src};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_request(src, seq, now);
	endtask

	// Sender gap: tvalid is held low for the number of cycles given.
	task automatic sender_gap(int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stop offering and wait until every predicted result has arrived. Each
	// request yields a result, so the pending predictions show when the block is empty.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write; only issued once the block has gone idle.
	task automatic write_cooldown(logic [15:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_cooldown(value);
		cur_cooldown = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Advance the stimulus clock by a step scaled to the cooldown, holding at
	// the top of the range once it gets there.
	task automatic advance_clock();
		logic [32:0] sum;
		int unsigned step;
		step = $urandom_range(0, cur_cooldown / 3 + 2);
		sum = {1'b0, clock_ms} + step;
		clock_ms = sum[32] ? pct_pkg::TIME_MAX : sum[31:0];
	endtask

	// Build one random request. Most are in-order traffic from the pool, the
	// rest are replays, invalid requests and fully random noise.
	task automatic make_request(output logic [15:0] src, output logic [31:0] seq,
			output logic [31:0] now);
		int r;
		int k;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, pool_n - 1);
		if (r < 70) begin
			advance_clock();
			pool_seq[k] = pool_seq[k] + $urandom_range(1, 3);
			src = pool_src[k];
			seq = pool_seq[k];
			now = clock_ms;
		end else if (r < 80) begin
			src = pool_src[k];
			seq = pool_seq[k] - $urandom_range(0, 2);
			now = clock_ms;
		end else if (r < 88) begin
			if ($urandom_range(0, 1) == 0) begin
				src = 16'd0;
				seq = $urandom;
			end else begin
				src = pool_src[k];
				seq = 32'd0;
			end
			now = clock_ms;
		end else begin
			src = 16'($urandom_range(0, 16'hFFFF));
			seq = $urandom;
			now = $urandom;
		end
	endtask

	initial begin
		logic [15:0] src;
		logic [31:0] seq;
		logic [31:0] now;
		int burst_left;

		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		cur_cooldown = pct_pkg::COOLDOWN_RESET;
		clock_ms = 32'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed part, with the reset cooldown of 120 ms.
		push_request(16'd0, 32'd5, 32'd1000);        // invalid source
		push_request(16'd7, 32'd0, 32'd1000);        // invalid sequence
		push_request(16'd0, 32'd0, 32'd0);           // both invalid
		// Fill all eight entries at the same time, the extreme ids among them.
		push_request(16'h0001, 32'd1, 32'd1000);
		push_request(16'hFFFF, 32'd1, 32'd1000);
		push_request(16'h1234, 32'd1, 32'd1000);
		push_request(16'h8000, 32'd1, 32'd1000);
		push_request(16'h00FF, 32'd1, 32'd1000);
		push_request(16'h5A5A, 32'd1, 32'd1000);
		push_request(16'hA5A5, 32'd1, 32'd1000);
		push_request(16'h7FFF, 32'd1, 32'd1000);
		// Table full and all next times equal: the first entry is replaced.
		push_request(16'h0009, 32'd1, 32'd1000);
		// Replayed sequence while still cooling: the replay check wins.
		push_request(16'hFFFF, 32'd1, 32'd1010);
		// Newer sequence but too early.
		push_request(16'hFFFF, 32'd2, 32'd1119);
		// Exactly at the next allowed time, largest sequence.
		push_request(16'hFFFF, 32'hFFFF_FFFF, 32'd1120);
		// Equal sequence is stale.
		push_request(16'hFFFF, 32'hFFFF_FFFF, 32'd5000);
		// The evicted source comes back as a new source.
		push_request(16'h0001, 32'd2, 32'd2000);
		// Time near the top: the next time saturates.
		push_request(16'h0009, 32'd2, 32'hFFFF_FFF0);
		push_request(16'h0009, 32'd3, 32'hFFFF_FFFF);
		push_request(16'h0009, 32'd4, 32'hFFFF_FFFF);
		drain();

		// Random phases, one cooldown setting each; the top-of-range clock
		// phase comes last since the clock stays saturated afterwards.
		for (int p = 0; p < 6; p++) begin
			drain();
			case (p)
				0: write_cooldown(16'd0);
				1: write_cooldown(16'd1);
				2: write_cooldown(16'($urandom_range(2, 16'hFFFE)));
				3: write_cooldown(pct_pkg::COOLDOWN_RESET);
				4: write_cooldown(16'($urandom_range(30, 300)));
				default: write_cooldown(16'hFFFF);
			endcase
			// A pool of 4 to 14 sources, at times larger than the table, can force evictions.
			pool_n = $urandom_range(4, 14);
			for (int k = 0; k < pool_n; k++) begin
				pool_src[k] = 16'($urandom_range(1, 16'hFFFF));
				pool_seq[k] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 50);
			end
			if (p == 5)
				clock_ms = 32'hFFF0_0000;
			burst_left = $urandom_range(1, 24);
			if (p == 3) begin
				// Long receiver hold-off while the sender keeps offering.
				hold_off = 1'b1;
				burst_left = 40;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 2 && n == PHASE_ITEMS / 2)
					drain();
				if (burst_left == 0) begin
					sender_gap($urandom_range(1, 8));
					burst_left = $urandom_range(1, 40);
				end
				make_request(src, seq, now);
				push_request(src, seq, now);
				burst_left--;
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("per_source_cooldown_table: match");
		else
			$display("per_source_cooldown_table: mismatch");
		$finish;
	end

endmodule
